// ----- design/bked_pkg.sv -----
// ----------------------------------------------------------------------------
// bked_pkg: shared types and codes for the button and knob event detector
// Item layouts, request and event codes, button modes and sequencer states.
// ----------------------------------------------------------------------------
package bked_pkg;

	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		REQ_BUTTON = 2'd0,
		REQ_KNOB   = 2'd1,
		REQ_POLL   = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		EV_PRESS   = 3'd0,
		EV_RELEASE = 3'd1,
		EV_LONG    = 3'd2,
		EV_KNOB    = 3'd3,
		EV_BAD_ID  = 3'd4
	} event_kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_PRESSED = 2'd1,
		MODE_LONG    = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUTTON,
		ST_KNOB,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_LONG_PRESS_MS = 2'd0,
		REG_BUTTON_MASK   = 2'd1,
		REG_KNOB_MASK     = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [3:0]         item_id;
		logic               pressed;
		logic signed [15:0] position;
		logic [31:0]        tick_ms;
	} req_item_t;

	typedef struct packed {
		logic [2:0]        event_kind;
		logic [3:0]        event_id;
		logic signed [7:0] knob_delta;
		logic              last;
	} evt_item_t;

endpackage

// ----- design/button_knob_event_detector.sv -----
// ----------------------------------------------------------------------------
// button_knob_event_detector
// Turns button levels, knob positions and poll ticks into press, release,
// long-press, knob-turn and bad-id events, using one shared subtract and
// compare unit under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  req       in         req_valid/req_ready  bked_pkg::req_item_t
//  evt       out        evt_valid/evt_ready  bked_pkg::evt_item_t
//  apb       in/out     psel/penable/pready  paddr[3:0], pwdata, prdata
//
//  A button or knob item is accepted, then makes one pass through the shared unit;
//  a poll walks the buttons one per cycle through the shared subtract/compare unit,
//  unless a scan stall holds it, then flushes the held long-press result. A full
//  output register stalls the sequencer while evt_ready is low.
//  Reset: all buttons idle, press times and knob positions zero, registers at
//  their defaults. req_ready is high only while the sequencer is idle.
//
module button_knob_event_detector #(
	parameter int BUTTONS = 8,
	parameter int KNOBS   = 4
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                req_valid,
	output logic                req_ready,
	input  bked_pkg::req_item_t req,

	output logic                evt_valid,
	input  logic                evt_ready,
	output bked_pkg::evt_item_t evt,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import bked_pkg::*;

	localparam int BTN_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam int KNB_W = (KNOBS > 1) ? $clog2(KNOBS) : 1;

	// configuration registers
	logic [31:0] long_press_q;
	logic [7:0]  bmask_q;
	logic [3:0]  kmask_q;

	// item registers, loaded on accept
	logic [3:0]         id_q;
	logic               pressed_q;
	logic signed [15:0] pos_q;
	logic [31:0]        tick_q;

	// sequencer
	state_t            state_q, state_d;
	logic [BTN_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_valid_q;
	logic [BTN_W-1:0]  pend_id_q;

	// stored state
	mode_t             mode_q [BUTTONS];
	logic [31:0]       press_time_q [BUTTONS];
	logic [15:0]       knob_pos_q [KNOBS];

	// output register
	logic              out_valid_q;
	evt_item_t         out_q;

	// control from the output block
	logic              emit;
	evt_item_t         emit_item;
	logic              mode_we;
	mode_t             mode_wdata;
	logic              pt_we;
	logic [31:0]       pt_wdata;
	logic              kpos_we;
	logic              pend_load;
	logic              pend_clr;
	logic              scan_adv;

	// datapath signals
	logic              req_fire;
	logic              cfg_write;
	logic              slot_free;
	logic [3:0]        idx4;
	logic              btn_en;
	logic              knob_en;
	logic              btn_bad;
	logic              knob_bad;
	logic [KNB_W-1:0]  kidx;
	mode_t             mode_rd;
	logic [31:0]       op_a;
	logic [31:0]       op_b;
	logic [31:0]       diff;
	logic              due;
	logic              scan_stall;
	logic              scan_end;

	assign pready    = 1'b1;
	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign cfg_write = psel && penable && pwrite && pready;
	assign slot_free = !out_valid_q || evt_ready;
	assign evt_valid = out_valid_q;
	assign evt       = out_q;

	// register read-back
	always_comb begin
		case (reg_index_t'(paddr[3:2]))
			REG_LONG_PRESS_MS: prdata = long_press_q;
			REG_BUTTON_MASK:   prdata = {24'd0, bmask_q};
			REG_KNOB_MASK:     prdata = {28'd0, kmask_q};
			default:           prdata = 32'd0;
		endcase
	end

	// Buttons and knobs past the mask width have no enable bit and count as enabled.
	assign idx4     = 4'(idx_q);
	assign btn_en   = idx4[3] || bmask_q[idx4[2:0]];
	assign knob_en  = id_q[3] || id_q[2] || kmask_q[id_q[1:0]];
	assign btn_bad  = {1'b0, id_q} >= 5'(BUTTONS);
	assign knob_bad = {1'b0, id_q} >= 5'(KNOBS);
	assign kidx     = id_q[KNB_W-1:0];
	assign mode_rd  = mode_q[idx_q];

	// Shared unit: one 32-bit subtract and one compare against the threshold.
	// Knob updates feed it zero-extended 16-bit positions.
	always_comb begin
		if (state_q == ST_KNOB) begin
			op_a = {16'd0, pos_q};
			op_b = knob_bad ? 32'd0 : {16'd0, knob_pos_q[kidx]};
		end else begin
			op_a = tick_q;
			op_b = press_time_q[idx_q];
		end
	end
	assign diff = op_a - op_b;

	assign due = btn_en && (mode_rd == MODE_PRESSED) &&
		(cnt_q < CNT_W'(MAX_RESULTS)) && (diff >= long_press_q);
	// Hold the scan when a new long press must push out the held one and the
	// output register is still full.
	assign scan_stall = due && pend_valid_q && !slot_free;
	assign scan_end   = (idx_q == BTN_W'(BUTTONS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (req_type_t'(req.req_type))
						REQ_BUTTON: state_d = ST_BUTTON;
						REQ_KNOB:   state_d = ST_KNOB;
						REQ_POLL:   state_d = ST_SCAN;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_BUTTON, ST_KNOB: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (!scan_stall && scan_end) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!pend_valid_q || slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		emit       = 1'b0;
		emit_item  = '0;
		mode_we    = 1'b0;
		mode_wdata = MODE_IDLE;
		pt_we      = 1'b0;
		pt_wdata   = 32'd0;
		kpos_we    = 1'b0;
		pend_load  = 1'b0;
		pend_clr   = 1'b0;
		scan_adv   = 1'b0;
		case (state_q)
			ST_BUTTON: begin
				if (slot_free) begin
					emit_item.event_id = id_q;
					emit_item.last     = 1'b1;
					if (btn_bad) begin
						emit                 = 1'b1;
						emit_item.event_kind = EV_BAD_ID;
					end else if (btn_en) begin
						if (pressed_q && mode_rd == MODE_IDLE) begin
							emit                 = 1'b1;
							emit_item.event_kind = EV_PRESS;
							mode_we              = 1'b1;
							mode_wdata           = MODE_PRESSED;
							pt_we                = 1'b1;
							pt_wdata             = tick_q;
						end else if (!pressed_q && mode_rd inside {MODE_PRESSED, MODE_LONG}) begin
							emit                 = 1'b1;
							emit_item.event_kind = EV_RELEASE;
							mode_we              = 1'b1;
							mode_wdata           = MODE_IDLE;
						end
					end
				end
			end
			ST_KNOB: begin
				if (slot_free) begin
					emit_item.event_id = id_q;
					emit_item.last     = 1'b1;
					if (knob_bad) begin
						emit                 = 1'b1;
						emit_item.event_kind = EV_BAD_ID;
					end else if (knob_en) begin
						kpos_we = 1'b1;
						if (diff[15:0] != 16'd0) begin
							emit                 = 1'b1;
							emit_item.event_kind = EV_KNOB;
							emit_item.knob_delta = diff[7:0];
						end
					end
				end
			end
			ST_SCAN: begin
				if (!scan_stall) begin
					scan_adv = 1'b1;
					if (due) begin
						mode_we    = 1'b1;
						mode_wdata = MODE_LONG;
						pend_load  = 1'b1;
						// the held long press is not the final one
						if (pend_valid_q) begin
							emit                 = 1'b1;
							emit_item.event_kind = EV_LONG;
							emit_item.event_id   = 4'(pend_id_q);
						end
					end
					if (btn_en && mode_rd == MODE_IDLE) begin
						pt_we    = 1'b1;
						pt_wdata = 32'd0;
					end
				end
			end
			ST_FLUSH: begin
				if (pend_valid_q && slot_free) begin
					emit                 = 1'b1;
					emit_item.event_kind = EV_LONG;
					emit_item.event_id   = 4'(pend_id_q);
					emit_item.last       = 1'b1;
					pend_clr             = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// configuration writes; writes past the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= 32'd1000;
			bmask_q      <= 8'hFF;
			kmask_q      <= 4'hF;
		end else if (cfg_write) begin
			case (reg_index_t'(paddr[3:2]))
				REG_LONG_PRESS_MS: long_press_q <= pwdata;
				REG_BUTTON_MASK:   bmask_q      <= pwdata[7:0];
				REG_KNOB_MASK:     kmask_q      <= pwdata[3:0];
				default:           long_press_q <= long_press_q;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (req_fire) begin
			id_q      <= req.item_id;
			pressed_q <= req.pressed;
			pos_q     <= req.position;
			tick_q    <= req.tick_ms;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_fire) begin
				// button updates address their own entry, polls start at zero
				idx_q        <= (req.req_type == REQ_BUTTON) ? req.item_id[BTN_W-1:0] : '0;
				cnt_q        <= '0;
				pend_valid_q <= 1'b0;
			end else begin
				if (scan_adv && !scan_end) idx_q <= idx_q + 1'b1;
				if (pend_load) begin
					pend_valid_q <= 1'b1;
					cnt_q        <= cnt_q + 1'b1;
				end else if (pend_clr) begin
					pend_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_load) pend_id_q <= idx_q;
	end

	// button and knob state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUTTONS; i++) begin
				mode_q[i]       <= MODE_IDLE;
				press_time_q[i] <= 32'd0;
			end
			for (int k = 0; k < KNOBS; k++) begin
				knob_pos_q[k] <= 16'd0;
			end
		end else begin
			if (mode_we) mode_q[idx_q] <= mode_wdata;
			if (pt_we) press_time_q[idx_q] <= pt_wdata;
			if (kpos_we) knob_pos_q[kidx] <= pos_q;
		end
	end

	// output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (evt_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= emit_item;
	end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for button_knob_event_detector
// Sends button, knob and poll items through the request channel with random
// gaps and random event-channel stalls. A scoreboard mirrors the button modes,
// press times and knob positions, predicts every event, and checks each one
// field by field. The run covers several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
	import bked_pkg::*;

	localparam int BUTTONS       = 8;
	localparam int KNOBS         = 4;
	// lets a poll that ends with no event run to its end
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 200000;

	// Mirror of the detector: predicts events at item acceptance, checks them on arrival
	class event_scoreboard;
		logic [31:0] hold_ms;
		logic [7:0]  button_on_mask;
		logic [3:0]  knob_on_mask;
		mode_t       btn_mode [BUTTONS];
		logic [31:0] pressed_at [BUTTONS];
		logic [15:0] knob_pos [KNOBS];
		evt_item_t   pending [$];
		int          errors;

		function new();
			hold_ms        = 32'd1000;
			button_on_mask = 8'hFF;
			knob_on_mask   = 4'hF;
			errors         = 0;
			foreach (btn_mode[i]) begin
				btn_mode[i]   = MODE_IDLE;
				pressed_at[i] = '0;
			end
			foreach (knob_pos[i])
				knob_pos[i] = '0;
		endfunction

		// buttons past the mask width have no enable bit and count as enabled
		function bit button_live(int i);
			return i >= 8 || button_on_mask[i];
		endfunction

		function void push_event(event_kind_t kind, int id, logic [7:0] delta, logic last);
			evt_item_t e;
			e.event_kind = kind;
			e.event_id   = 4'(id);
			e.knob_delta = delta;
			e.last       = last;
			pending.push_back(e);
		endfunction

		function void note_request(req_item_t r);
			logic [15:0] moved;
			logic [31:0] held;
			int          id;
			int          found;
			id    = r.item_id;
			found = 0;
			case (req_type_t'(r.req_type))
				REQ_BUTTON: begin
					if (id >= BUTTONS) begin
						push_event(EV_BAD_ID, id, 8'd0, 1'b1);
					end else if (button_live(id)) begin
						if (r.pressed && btn_mode[id] == MODE_IDLE) begin
							btn_mode[id]   = MODE_PRESSED;
							pressed_at[id] = r.tick_ms;
							push_event(EV_PRESS, id, 8'd0, 1'b1);
						end else if (!r.pressed && btn_mode[id] != MODE_IDLE) begin
							btn_mode[id] = MODE_IDLE;
							push_event(EV_RELEASE, id, 8'd0, 1'b1);
						end
					end
				end
				REQ_KNOB: begin
					if (id >= KNOBS) begin
						push_event(EV_BAD_ID, id, 8'd0, 1'b1);
					end else if (id >= 4 || knob_on_mask[id]) begin
						moved        = r.position - knob_pos[id];
						knob_pos[id] = r.position;
						if (moved != 16'd0)
							push_event(EV_KNOB, id, moved[7:0], 1'b1);
					end
				end
				REQ_POLL: begin
					for (int i = 0; i < BUTTONS; i++) begin
						if (!button_live(i))
							continue;
						held = r.tick_ms - pressed_at[i];
						if (btn_mode[i] == MODE_PRESSED && found < MAX_RESULTS &&
							held >= hold_ms) begin
							btn_mode[i] = MODE_LONG;
							push_event(EV_LONG, i, 8'd0, 1'b0);
							found++;
						end
						if (btn_mode[i] == MODE_IDLE)
							pressed_at[i] = '0;
					end
					if (found > 0)
						pending[pending.size() - 1].last = 1'b1;
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_event(evt_item_t got);
			evt_item_t want;
			if (pending.size() == 0) begin
				report($sformatf("event with nothing expected: kind %0d id %0d delta %0d",
					got.event_kind, got.event_id, got.knob_delta));
				return;
			end
			want = pending.pop_front();
			if (got.event_kind !== want.event_kind)
				report($sformatf("event_kind %0d, expected %0d", got.event_kind,
					want.event_kind));
			if (got.event_id !== want.event_id)
				report($sformatf("event_id %0d, expected %0d", got.event_id, want.event_id));
			if (got.knob_delta !== want.knob_delta)
				report($sformatf("knob_delta %0d, expected %0d", got.knob_delta,
					want.knob_delta));
			if (got.last !== want.last)
				report($sformatf("last %0b, expected %0b", got.last, want.last));
		endtask
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_item_t   req       = '0;
	logic        evt_valid;
	logic        evt_ready = 1'b0;
	evt_item_t   evt;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [3:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	bit          steady = 1'b0;   // no gaps and no stalls while set
	logic [31:0] now_ms = '0;     // running millisecond clock for the stimulus
	int          cycles = 0;

	event_scoreboard sb = new();

	button_knob_event_detector #(
		.BUTTONS(BUTTONS),
		.KNOBS  (KNOBS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt      (evt),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// Stall the event channel about a quarter of the time
	always @(posedge clk) begin
		evt_ready <= steady || ($urandom_range(0, 99) >= 24);
	end

	// Check every event taken at this edge against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && evt_valid && evt_ready)
			sb.check_event(evt);
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL button_knob_event_detector");
			$finish;
		end
	end

	function automatic req_item_t make_request(req_type_t kind, logic [3:0] id, logic level,
		logic [15:0] pos, logic [31:0] ms);
		req_item_t r;
		r.req_type = kind;
		r.item_id  = id;
		r.pressed  = level;
		r.position = pos;
		r.tick_ms  = ms;
		return r;
	endfunction

	// Offer one item and hold it until taken. Valid stays high into the next
	// item unless a gap is drawn, so it is never lowered and raised in one step.
	task automatic send_request(req_item_t r);
		int gap;
		if (!steady && $urandom_range(0, 99) < 24) begin
			gap = 1;
			while (gap < 8 && $urandom_range(0, 99) < 24)
				gap++;
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
	endtask

	// Setup then access; back-to-back writes go straight from access to setup
	task automatic write_register(reg_index_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apply_config(logic [31:0] hold, logic [7:0] btn_mask, logic [3:0] knob_mask);
		write_register(REG_LONG_PRESS_MS, hold);
		write_register(REG_BUTTON_MASK, {24'd0, btn_mask});
		write_register(REG_KNOB_MASK, {28'd0, knob_mask});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.hold_ms        = hold;
		sb.button_on_mask = btn_mask;
		sb.knob_on_mask   = knob_mask;
	endtask

	// Drop valid, wait out every predicted event, then let a silent poll finish
	task automatic settle_out();
		req_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed traffic on a running clock, with some bad ids,
	// out-of-order times and unused request types mixed in
	task automatic random_items(int count, int unsigned step_max);
		req_item_t   r;
		logic [15:0] base;
		int unsigned pick;
		int          made;
		made = 0;
		while (made < count) begin
			now_ms = now_ms + $urandom_range(0, step_max);
			r = '0;
			r.tick_ms = ($urandom_range(0, 19) == 0) ? $urandom() : now_ms;
			pick = $urandom_range(0, 99);
			if (pick < 42) begin
				r.req_type = REQ_BUTTON;
				r.item_id  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
					: 4'($urandom_range(0, 7));
				r.pressed  = 1'($urandom_range(0, 1));
				made++;
			end else if (pick < 66) begin
				r.req_type = REQ_KNOB;
				r.item_id  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(4, 15))
					: 4'($urandom_range(0, 3));
				base = sb.knob_pos[r.item_id[1:0]];
				pick = $urandom_range(0, 7);
				if (pick < 2)
					r.position = 16'($urandom());
				else if (pick == 2)
					r.position = base;
				else if (pick == 3)
					r.position = base + 16'(256 * $urandom_range(1, 3));
				else
					r.position = base + 16'($urandom_range(0, 300)) - 16'd150;
				made++;
			end else if (pick < 95) begin
				r.req_type = REQ_POLL;
				r.item_id  = 4'($urandom_range(0, 15));
				made++;
			end else begin
				r.req_type = REQ_NONE;
				r.item_id  = 4'($urandom_range(0, 15));
				r.pressed  = 1'($urandom_range(0, 1));
				r.position = 16'($urandom());
			end
			send_request(r);
		end
	endtask

	// Edges of every field, each request kind, wrap-around and a full poll
	task automatic directed_items();
		send_request(make_request(REQ_NONE, 4'hF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
		send_request(make_request(REQ_BUTTON, 4'd0, 1'b1, 16'd0, 32'd100));
		send_request(make_request(REQ_BUTTON, 4'd0, 1'b1, 16'd0, 32'd150));
		send_request(make_request(REQ_BUTTON, 4'd7, 1'b1, 16'd0, 32'd0));
		// button 0 one short of the threshold, then exactly on it;
		// button 7 already past it at the first poll
		send_request(make_request(REQ_POLL, 4'd0, 1'b0, 16'd0, 32'd1099));
		send_request(make_request(REQ_POLL, 4'd0, 1'b0, 16'd0, 32'd1100));
		send_request(make_request(REQ_BUTTON, 4'd7, 1'b0, 16'd0, 32'd1200));
		send_request(make_request(REQ_BUTTON, 4'd0, 1'b0, 16'd0, 32'd1201));
		send_request(make_request(REQ_BUTTON, 4'd5, 1'b0, 16'd0, 32'd1202));
		send_request(make_request(REQ_BUTTON, 4'd8, 1'b1, 16'd0, 32'd1300));
		send_request(make_request(REQ_BUTTON, 4'd15, 1'b0, 16'd0, 32'd1301));
		// knob deltas: max position, full-scale swing, no change, a multiple
		// of 256 that wraps to zero, and the most negative wrapped value
		send_request(make_request(REQ_KNOB, 4'd0, 1'b0, 16'h7FFF, 32'd0));
		send_request(make_request(REQ_KNOB, 4'd0, 1'b0, 16'h8000, 32'd0));
		send_request(make_request(REQ_KNOB, 4'd0, 1'b0, 16'h8000, 32'd0));
		send_request(make_request(REQ_KNOB, 4'd1, 1'b0, 16'h0100, 32'd0));
		send_request(make_request(REQ_KNOB, 4'd3, 1'b0, 16'h0080, 32'd0));
		send_request(make_request(REQ_KNOB, 4'd4, 1'b1, 16'h1234, 32'd0));
		send_request(make_request(REQ_KNOB, 4'd15, 1'b0, 16'hFFFF, 32'd0));
		// every button down at once, then one poll that reports all of them
		for (int i = 0; i < BUTTONS; i++)
			send_request(make_request(REQ_BUTTON, 4'(i), 1'b1, 16'd0, 32'd5000));
		send_request(make_request(REQ_POLL, 4'd0, 1'b0, 16'd0, 32'd6000));
	endtask

	initial begin
		// hold reset, release it once
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at their reset values
		directed_items();

		// threshold zero: any held button turns long at the next poll
		settle_out();
		apply_config(32'd0, 8'hFF, 4'hF);
		steady = 1'b1;
		random_items(90, 50);
		steady = 1'b0;

		// largest threshold: only a held time of all ones qualifies
		settle_out();
		apply_config(32'hFFFF_FFFF, 8'hFF, 4'hF);
		send_request(make_request(REQ_BUTTON, 4'd3, 1'b0, 16'd0, 32'd3));
		send_request(make_request(REQ_BUTTON, 4'd3, 1'b1, 16'd0, 32'd5));
		send_request(make_request(REQ_POLL, 4'd0, 1'b0, 16'd0, 32'd4));
		random_items(40, 2000);

		// everything disabled: only bad ids report
		settle_out();
		apply_config(32'd0, 8'h00, 4'h0);
		random_items(40, 100);

		// random settings, the last one running the clock across the wrap
		for (int k = 0; k < 3; k++) begin
			settle_out();
			apply_config(32'($urandom_range(10, 600)), 8'($urandom()), 4'($urandom()));
			if (k == 2)
				now_ms = 32'hFFFF_F000;
			random_items(80, 200);
		end

		settle_out();
		if (sb.errors == 0)
			$display("PASS button_knob_event_detector");
		else
			$display("FAIL button_knob_event_detector");
		$finish;
	end

endmodule
